FILE: src/ptt_pkg.sv
// package for the periodic timer table: word types, operation and status codes,
// controller states and the command/status structs between controller and datapath
// no dependencies
package ptt_pkg;

  // default number of timer slots
  localparam int TIMER_SLOTS_DEF = 16;

  // operation codes carried in the input word
  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_START   = 2'd1,
    OP_TICK    = 2'd2,
    OP_SERVICE = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_BAD_ID = 2'd2
  } sts_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_START_WR,
    S_SCAN,
    S_FINISH
  } state_e;

  // input word
  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  slot_id;
    logic [31:0] interval;
    logic [31:0] now;
  } ptt_in_t;

  // result word
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  assigned_id;
    logic [15:0] fired_mask;
    logic [4:0]  timer_total;
  } ptt_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic start_wr;
    logic scan_step;
    logic load_out;
  } ptt_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic id_ok;
    logic scan_done;
    logic out_free;
  } ptt_stat_t;

endpackage

FILE: src/ptt_ctrl.sv
// controller for the periodic timer table: sequences add, start and the slot scans
// depends on ptt_pkg
module ptt_ctrl import ptt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ptt_stat_t stat_i,
  output ptt_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        unique case (stat_i.op)
          OP_ADD:   state_d = S_FINISH;
          OP_START: state_d = stat_i.id_ok ? S_START_WR : S_FINISH;
          default:  state_d = S_SCAN;
        endcase
      end
      S_START_WR: begin
        cmd_o.start_wr = 1'b1;
        state_d        = S_FINISH;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.load_out = 1'b1;
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: src/ptt_dp.sv
// datapath for the periodic timer table: interval and deadline memories, slot flags,
// scan pipeline, result accumulation and output register
// depends on ptt_pkg
module ptt_dp import ptt_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ptt_in_t   in_data_i,
  input  ptt_cmd_t  cmd_i,
  output ptt_stat_t stat_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output ptt_out_t  out_data_o
);

  localparam int IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CntW = $clog2(TIMER_SLOTS + 1);
  localparam int CmpW = (CntW > 4) ? CntW : 4;

  // timer tables, no reset
  logic [31:0] interval_mem [TIMER_SLOTS];
  logic [31:0] deadline_mem [TIMER_SLOTS];
  logic [31:0] ivl_rd_q, dl_rd_q;

  ptt_in_t          req_q;
  logic [CntW-1:0]  count_q;
  logic [TIMER_SLOTS-1:0] running_q, expired_q;
  logic [CntW-1:0]  rd_idx_q;
  logic             proc_vld_q;
  logic [IdxW-1:0]  proc_idx_q;
  logic [1:0]       sts_q;
  logic [3:0]       asg_q;
  logic [15:0]      mask_q;
  ptt_out_t         out_q;
  logic             out_vld_q;

  op_e             op;
  logic            full, id_ok, scan_more, add_wr, rd_en;
  logic [IdxW-1:0] id_idx, cnt_idx, rd_addr, dl_waddr;
  logic [31:0]     diff, rearm;
  logic            passed, run_p, exp_p, svc_hit, hit, dl_we;
  logic            out_free;

  // decode of the held word
  assign op        = op_e'(req_q.operation);
  assign full      = count_q >= CntW'(TIMER_SLOTS);
  assign id_ok     = CmpW'(req_q.slot_id) < CmpW'(count_q);
  assign scan_more = rd_idx_q < count_q;
  assign id_idx    = IdxW'(req_q.slot_id);
  assign cnt_idx   = count_q[IdxW-1:0];
  assign add_wr    = cmd_i.decode && (op == OP_ADD) && !full;

  // table read port, shared by start and the scan
  assign rd_addr = (op == OP_START) ? id_idx : rd_idx_q[IdxW-1:0];
  assign rd_en   = (cmd_i.decode && (op == OP_START)) || (cmd_i.scan_step && scan_more);

  // slot check on the word read last cycle
  assign diff    = dl_rd_q - req_q.now;
  assign passed  = (diff == 32'd0) || diff[31];
  assign run_p   = running_q[proc_idx_q];
  assign exp_p   = expired_q[proc_idx_q];
  assign svc_hit = run_p && exp_p;
  assign hit     = proc_vld_q &&
                   ((op == OP_TICK) ? (run_p && (exp_p || passed)) : svc_hit);

  // deadline write: start or re-arm on service
  assign rearm    = req_q.now + ivl_rd_q;
  assign dl_we    = cmd_i.start_wr || (proc_vld_q && (op == OP_SERVICE) && svc_hit);
  assign dl_waddr = cmd_i.start_wr ? id_idx : proc_idx_q;

  assign out_free = !out_vld_q || out_ready_i;

  // interval memory
  always_ff @(posedge clk_i) begin
    if (add_wr) begin
      interval_mem[cnt_idx] <= req_q.interval;
    end
    if (rd_en) begin
      ivl_rd_q <= interval_mem[rd_addr];
    end
  end

  // deadline memory
  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      deadline_mem[dl_waddr] <= rearm;
    end
    if (rd_en) begin
      dl_rd_q <= deadline_mem[rd_addr];
    end
  end

  // slot count, flags and scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      running_q  <= '0;
      expired_q  <= '0;
      rd_idx_q   <= '0;
      proc_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (add_wr) begin
        running_q[cnt_idx] <= 1'b0;
        expired_q[cnt_idx] <= 1'b0;
        count_q            <= count_q + CntW'(1);
      end
      if (cmd_i.start_wr) begin
        running_q[id_idx] <= 1'b1;
      end
      if (proc_vld_q) begin
        if (op == OP_TICK) begin
          expired_q[proc_idx_q] <= exp_p || (run_p && passed);
        end else if (svc_hit) begin
          expired_q[proc_idx_q] <= 1'b0;
        end
      end
      if (cmd_i.decode) begin
        rd_idx_q   <= '0;
        proc_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        proc_vld_q <= scan_more;
        if (scan_more) begin
          rd_idx_q <= rd_idx_q + CntW'(1);
        end
      end
      if (cmd_i.load_out && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // held word, scan index and result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= in_data_i;
      sts_q  <= STS_OK;
      asg_q  <= 4'd0;
      mask_q <= 16'd0;
    end
    if (cmd_i.decode && (op == OP_ADD)) begin
      if (full) begin
        sts_q <= STS_FULL;
      end else begin
        asg_q <= 4'(count_q);
      end
    end
    if (cmd_i.decode && (op == OP_START) && !id_ok) begin
      sts_q <= STS_BAD_ID;
    end
    if (cmd_i.scan_step && scan_more) begin
      proc_idx_q <= rd_idx_q[IdxW-1:0];
    end
    // slots above bit 15 are dropped from the mask
    for (int b = 0; b < 16; b++) begin
      if (hit && (int'(proc_idx_q) == b)) begin
        mask_q[b] <= 1'b1;
      end
    end
    if (cmd_i.load_out && out_free) begin
      out_q.status      <= sts_q;
      out_q.assigned_id <= asg_q;
      out_q.fired_mask  <= mask_q;
      out_q.timer_total <= 5'(count_q);
    end
  end

  // status to controller
  assign stat_o.op        = op;
  assign stat_o.id_ok     = id_ok;
  assign stat_o.scan_done = !scan_more && !proc_vld_q;
  assign stat_o.out_free  = out_free;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/periodic_timer_table_core.sv
// periodic timer table: one word in, one result word out per operation; depends on ptt_pkg,
// ptt_ctrl and ptt_dp. add decodes and finishes; start decodes, writes the deadline when the
// slot id is valid, then finishes; tick and service scan the added timers one slot per cycle.
// one operation at a time, a new word is taken only in idle; a waiting result does not
// block input, but the next result waits in the controller's finish state for a free output.
// reset clears the slot count and flags; tables are undefined until written, no clearing pass.
module periodic_timer_table_core import ptt_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ptt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ptt_out_t out_data_o
);

  ptt_cmd_t  cmd;
  ptt_stat_t stat;

  // sequencer
  ptt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // tables, flags and result
  ptt_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
